FILE: sv/drcf_pkg.sv
// Shared types and constants for the dual-range current fusion block.
// No dependencies; used by drcf_alu and dual_range_current_fusion.
`timescale 1ns / 1ps
`default_nettype none

package drcf_pkg;

    // default sample width, signed milliamps
    localparam int SAMPLE_WIDTH_DEF = 22;

    // configuration register widths
    localparam int LIMIT_W = 21;
    localparam int BLEND_W = 20;

    // reset values of the configuration registers
    localparam logic [LIMIT_W-1:0] HIGH_RAIL_RST = 21'd2000000;
    localparam logic [LIMIT_W-1:0] LOW_RAIL_RST  = 21'd200000;
    localparam logic [LIMIT_W-1:0] SWITCH_RST    = 21'd150000;
    localparam logic [BLEND_W-1:0] BLEND_RST     = 20'd20000;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_HIGH_RAIL = 2'd0,
        REG_LOW_RAIL  = 2'd1,
        REG_SWITCH    = 2'd2,
        REG_BLEND     = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_RES
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

`default_nettype wire

FILE: sv/dual_range_current_fusion.sv
// Dual-range current fusion: channel health, band selection and serial crossfade.
// Depends on drcf_pkg and drcf_alu.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+---------------------------------------------------
//  input    | i_valid  | o_stall  | i_current_high, i_current_low
//  output   | o_valid  | i_stall  | o_fused_current, o_fused_status,
//           |          |          | o_high_healthy, o_low_healthy
//  config   | APB      | pready=1 | psel, penable, pwrite, paddr, pwdata, prdata
//
// After evaluation, a crossfaded item takes one shift-add step per bit of the blend
// offset, then one restoring divide step per quotient bit and a final sum, all on the
// one shared adder, before it reaches the output register. Items that are not
// crossfaded go from evaluation straight to the result. One item is in flight at a time.
// A finished item waits in the output register, so the next item is taken meanwhile.
// Reset is synchronous; it restores the register defaults and clears held current.
`timescale 1ns / 1ps
`default_nettype none

module dual_range_current_fusion #(
    parameter int SAMPLE_WIDTH = drcf_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [SAMPLE_WIDTH-1:0]            i_current_high,
    input  wire logic [SAMPLE_WIDTH-1:0]            i_current_low,
    // output channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [SAMPLE_WIDTH-1:0]                 o_fused_current,
    output logic                                    o_fused_status,
    output logic                                    o_high_healthy,
    output logic                                    o_low_healthy,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [drcf_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [drcf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [drcf_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int LW   = drcf_pkg::LIMIT_W;
    localparam int DW   = drcf_pkg::BLEND_W;
    localparam int CW   = ((SW > LW + 1) ? SW : LW + 1) + 1;
    localparam int PW   = DW + SW;
    localparam int AW   = PW + 1;
    localparam int MAXN = (DW > SW) ? DW : SW;
    localparam int CNTW = $clog2(MAXN);

    // configuration registers
    logic [LW-1:0] r_high_rail, r_low_rail, r_switch;
    logic [DW-1:0] r_blend;

    // working state
    drcf_pkg::t_state r_state, n_state;
    logic [SW-1:0]    r_hi, r_lo, r_mag, r_res, r_held;
    logic             r_hok, r_lok, r_miss, r_neg;
    logic [DW-1:0]    r_d, r_weff, r_rem;
    logic [PW-1:0]    r_acc;
    logic [CNTW-1:0]  r_cnt;

    // output register
    logic             r_o_valid;
    logic [SW-1:0]    r_o_current;
    logic             r_o_status, r_o_hok, r_o_lok;

    logic cfg_wr, in_take, out_free;

    // evaluation of the captured pair
    logic [SW-1:0] ahi, alo, dmag, ev_res;
    logic [SW:0]   diff, diff_n;
    logic [CW-1:0] ahi_c, alo_c, band_c, half_c, sp_c, alo_half_c, d_c;
    logic [DW-1:0] w_eff;
    logic          hok, lok, above_band, above_start, use_hi, blend;

    // shared adder
    logic [AW-1:0]     alu_a, alu_b, alu_sum;
    drcf_pkg::t_alu_op alu_op;
    logic              div_ge;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        unique case (drcf_pkg::t_reg_idx'(paddr[3:2]))
            drcf_pkg::REG_HIGH_RAIL: prdata = drcf_pkg::APB_DATA_W'(r_high_rail);
            drcf_pkg::REG_LOW_RAIL:  prdata = drcf_pkg::APB_DATA_W'(r_low_rail);
            drcf_pkg::REG_SWITCH:    prdata = drcf_pkg::APB_DATA_W'(r_switch);
            drcf_pkg::REG_BLEND:     prdata = drcf_pkg::APB_DATA_W'(r_blend);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_rail <= drcf_pkg::HIGH_RAIL_RST;
            r_low_rail  <= drcf_pkg::LOW_RAIL_RST;
            r_switch    <= drcf_pkg::SWITCH_RST;
            r_blend     <= drcf_pkg::BLEND_RST;
        end else if (cfg_wr) begin
            unique case (drcf_pkg::t_reg_idx'(paddr[3:2]))
                drcf_pkg::REG_HIGH_RAIL: r_high_rail <= pwdata[LW-1:0];
                drcf_pkg::REG_LOW_RAIL:  r_low_rail  <= pwdata[LW-1:0];
                drcf_pkg::REG_SWITCH:    r_switch    <= pwdata[LW-1:0];
                drcf_pkg::REG_BLEND:     r_blend     <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // health checks and band decision
    always_comb begin
        ahi    = r_hi[SW-1] ? SW'(~r_hi + 1'b1) : r_hi;
        alo    = r_lo[SW-1] ? SW'(~r_lo + 1'b1) : r_lo;
        diff   = {r_hi[SW-1], r_hi} - {r_lo[SW-1], r_lo};
        diff_n = ~diff + 1'b1;
        dmag   = diff[SW] ? diff_n[SW-1:0] : diff[SW-1:0];
        // a zero width means a band of one milliamp
        w_eff  = (r_blend == '0) ? DW'(1) : r_blend;

        ahi_c      = CW'(ahi);
        alo_c      = CW'(alo);
        half_c     = CW'(w_eff >> 1);
        sp_c       = CW'(r_switch);
        band_c     = sp_c + half_c;
        alo_half_c = alo_c + half_c;
        // offset into the band, at most the width when blending
        d_c        = alo_half_c - sp_c;

        hok         = ahi_c < CW'(r_high_rail);
        lok         = alo_c < CW'(r_low_rail);
        above_band  = alo_c > band_c;
        above_start = alo_half_c > sp_c;
        use_hi      = hok && (above_band || !lok);
        blend       = !use_hi && hok && lok && above_start;

        priority if (use_hi) begin
            ev_res = r_hi;
        end else if (lok) begin
            ev_res = r_lo;
        end else begin
            ev_res = r_held;
        end
    end

    drcf_alu #(
        .WIDTH (AW)
    ) u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_op  (alu_op),
        .o_sum (alu_sum)
    );

    assign div_ge = !alu_sum[AW-1];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            drcf_pkg::ST_IDLE: if (in_take) n_state = drcf_pkg::ST_EVAL;
            drcf_pkg::ST_EVAL: n_state = blend ? drcf_pkg::ST_MUL : drcf_pkg::ST_RES;
            drcf_pkg::ST_MUL:  if (r_cnt == '0) n_state = drcf_pkg::ST_DIV;
            drcf_pkg::ST_DIV:  if (r_cnt == '0) n_state = drcf_pkg::ST_FIN;
            drcf_pkg::ST_FIN:  n_state = drcf_pkg::ST_RES;
            drcf_pkg::ST_RES:  if (out_free) n_state = drcf_pkg::ST_IDLE;
            default:           n_state = drcf_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and adder operands
    always_comb begin
        o_stall = (r_state != drcf_pkg::ST_IDLE);
        alu_a   = '0;
        alu_b   = '0;
        alu_op  = drcf_pkg::ALU_ADD;
        unique case (r_state)
            drcf_pkg::ST_MUL: begin
                alu_a = AW'({r_acc[PW-2:0], 1'b0});
                alu_b = r_d[DW-1] ? AW'(r_mag) : '0;
            end
            drcf_pkg::ST_DIV: begin
                alu_a  = AW'({r_rem, r_acc[SW-1]});
                alu_b  = AW'(r_weff);
                alu_op = drcf_pkg::ALU_SUB;
            end
            drcf_pkg::ST_FIN: begin
                alu_a  = {{(AW-SW){r_lo[SW-1]}}, r_lo};
                alu_b  = AW'(r_acc[SW-1:0]);
                alu_op = r_neg ? drcf_pkg::ALU_SUB : drcf_pkg::ALU_ADD;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= drcf_pkg::ST_IDLE;
            r_held    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == drcf_pkg::ST_RES && out_free) begin
                r_o_valid <= 1'b1;
                r_held    <= r_res;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            drcf_pkg::ST_IDLE: begin
                if (in_take) begin
                    r_hi <= i_current_high;
                    r_lo <= i_current_low;
                end
            end
            drcf_pkg::ST_EVAL: begin
                r_hok  <= hok;
                r_lok  <= lok;
                r_miss <= !hok && !lok;
                r_res  <= ev_res;
                r_neg  <= diff[SW];
                r_mag  <= dmag;
                r_d    <= d_c[DW-1:0];
                r_weff <= w_eff;
                r_acc  <= '0;
                r_cnt  <= CNTW'(DW - 1);
            end
            drcf_pkg::ST_MUL: begin
                // MSB-first shift-add of offset times difference magnitude
                r_acc <= alu_sum[PW-1:0];
                r_d   <= {r_d[DW-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_rem <= alu_sum[PW-1:SW];
                    r_cnt <= CNTW'(SW - 1);
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            drcf_pkg::ST_DIV: begin
                // restoring step: shift in next product bit, quotient bit out
                r_rem <= div_ge ? alu_sum[DW-1:0] : alu_a[DW-1:0];
                r_acc <= {r_acc[PW-1:SW], r_acc[SW-2:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            drcf_pkg::ST_FIN: begin
                r_res <= alu_sum[SW-1:0];
            end
            drcf_pkg::ST_RES: begin
                if (out_free) begin
                    r_o_current <= r_res;
                    r_o_status  <= r_miss;
                    r_o_hok     <= r_hok;
                    r_o_lok     <= r_lok;
                end
            end
            default: ;
        endcase
    end

    assign o_valid         = r_o_valid;
    assign o_fused_current = r_o_current;
    assign o_fused_status  = r_o_status;
    assign o_high_healthy  = r_o_hok;
    assign o_low_healthy   = r_o_lok;

    // remainder stays below the divisor through every divide step
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drcf_pkg::ST_DIV) |-> (r_rem < r_weff))
        else $error("divide remainder reached the divisor");

    // a held result is never overwritten while the output is stalled
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drcf_pkg::ST_RES && r_o_valid && i_stall)
        |=> (r_state == drcf_pkg::ST_RES && $stable(r_o_current)))
        else $error("result left while output stalled");

    // missing status only when both channels are railed
    a_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fused_status) |-> (!o_high_healthy && !o_low_healthy))
        else $error("missing status with a healthy channel");

    // an accepted item is evaluated in the next cycle
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == drcf_pkg::ST_EVAL))
        else $error("accepted item not evaluated");

endmodule

`default_nettype wire

FILE: sv/drcf_alu.sv
// Shared add/subtract unit for the crossfade multiply, divide and final sum.
// Depends on drcf_pkg for the operation code.
`timescale 1ns / 1ps
`default_nettype none

module drcf_alu #(
    parameter int WIDTH = 43
) (
    input  wire logic [WIDTH-1:0]      i_a,
    input  wire logic [WIDTH-1:0]      i_b,
    input  wire drcf_pkg::t_alu_op     i_op,
    output logic [WIDTH-1:0]           o_sum
);

    always_comb begin
        unique case (i_op)
            drcf_pkg::ALU_ADD: o_sum = i_a + i_b;
            drcf_pkg::ALU_SUB: o_sum = i_a - i_b;
            default:           o_sum = i_a + i_b;
        endcase
    end

endmodule

`default_nettype wire
